### src/pic_pkg.sv
// ============================================================================
// pic_pkg
// Shared types and constants for the priority interrupt controller.
// ============================================================================
package pic_pkg;

    localparam int WORD_W      = 32;
    localparam int NORMAL_EV_W = 30;
    localparam int LEVEL_MASKS = 9;
    localparam int TRIG_MASKS  = 4;

    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 7;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [2:0] {
        CMD_READ         = 3'd0,
        CMD_WRITE        = 3'd1,
        CMD_RAISE_NORMAL = 3'd2,
        CMD_SET_EXTERNAL = 3'd3,
        CMD_RAISE_ERROR  = 3'd4
    } cmd_t;

    localparam logic [3:0] REG_NORMAL     = 4'd0;
    localparam logic [3:0] REG_EXTERNAL   = 4'd1;
    localparam logic [3:0] REG_ERROR      = 4'd2;
    localparam logic [3:0] REG_MASK_FIRST = 4'd3;
    localparam logic [3:0] REG_MASK_LAST  = 4'd11;
    localparam logic [3:0] REG_TRIG_FIRST = 4'd12;

    localparam int TRIG_PVR_NORMAL = 0;
    localparam int TRIG_PVR_EXT    = 1;
    localparam int TRIG_G2_NORMAL  = 2;
    localparam int TRIG_G2_EXT     = 3;

    localparam int LVL2_BASE = 0;
    localparam int LVL4_BASE = 3;
    localparam int LVL6_BASE = 6;

    localparam logic [2:0] LEVEL_NONE = 3'd0;
    localparam logic [2:0] LEVEL_2    = 3'd2;
    localparam logic [2:0] LEVEL_4    = 3'd4;
    localparam logic [2:0] LEVEL_6    = 3'd6;
    localparam logic [3:0] IRL_TOP    = 4'd15;

    typedef struct packed {
        cmd_t              command;
        logic [3:0]        reg_index;
        logic [WORD_W-1:0] write_data;
        logic              wave_armed;
        logic              pvr_armed;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0]                  normal;
        logic [WORD_W-1:0]                  external;
        logic [WORD_W-1:0]                  error;
        logic [LEVEL_MASKS-1:0][WORD_W-1:0] level_mask;
        logic [TRIG_MASKS-1:0][WORD_W-1:0]  trig_mask;
    } pic_state_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic [2:0]        irq_level;
        logic [3:0]        irl_code;
        logic              wave_dma_trigger;
        logic              pvr_dma_trigger;
    } result_t;

endpackage

### src/pic_regs.sv
// ============================================================================
// pic_regs
// Status words and mask registers, with their update on each transfer.
// ============================================================================
module pic_regs (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  pic_pkg::item_t           item,
    output logic [pic_pkg::WORD_W-1:0] read_data,
    output pic_pkg::pic_state_t      state_next
);
    import pic_pkg::*;

    logic [NORMAL_EV_W-1:0]  normal_reg,   normal_next;
    logic [WORD_W-1:0]       external_reg, external_next;
    logic [WORD_W-1:0]       error_reg,    error_next;
    logic [LEVEL_MASKS-1:0][WORD_W-1:0] level_mask_reg, level_mask_next;
    logic [TRIG_MASKS-1:0][WORD_W-1:0]  trig_mask_reg,  trig_mask_next;

    logic [3:0]        mask_idx;
    logic [1:0]        trig_idx;
    logic [WORD_W-1:0] normal_view;

    assign mask_idx    = 4'(item.reg_index - REG_MASK_FIRST);
    assign trig_idx    = item.reg_index[1:0];
    assign normal_view = {(error_reg != '0), (external_reg != '0), normal_reg};

    always_comb
    begin
        normal_next     = normal_reg;
        external_next   = external_reg;
        error_next      = error_reg;
        level_mask_next = level_mask_reg;
        trig_mask_next  = trig_mask_reg;
        read_data       = '0;
        case (item.command)
            CMD_READ:
            begin
                if (item.reg_index == REG_NORMAL)
                    read_data = normal_view;
                else if (item.reg_index == REG_EXTERNAL)
                    read_data = external_reg;
                else if (item.reg_index == REG_ERROR)
                    read_data = error_reg;
                else if (item.reg_index <= REG_MASK_LAST)
                    read_data = level_mask_reg[mask_idx];
                else
                    read_data = trig_mask_reg[trig_idx];
            end
            CMD_WRITE:
            begin
                if (item.reg_index == REG_NORMAL)
                    normal_next = normal_reg & ~item.write_data[NORMAL_EV_W-1:0];
                else if (item.reg_index == REG_ERROR)
                    error_next = error_reg & ~item.write_data;
                else if (item.reg_index == REG_EXTERNAL)
                    external_next = external_reg;
                else if (item.reg_index <= REG_MASK_LAST)
                    level_mask_next[mask_idx] = item.write_data;
                else
                    trig_mask_next[trig_idx] = item.write_data;
            end
            CMD_RAISE_NORMAL: normal_next   = normal_reg | item.write_data[NORMAL_EV_W-1:0];
            CMD_SET_EXTERNAL: external_next = item.write_data;
            CMD_RAISE_ERROR:  error_next    = error_reg | item.write_data;
            default:          read_data     = '0;
        endcase
    end

    always_comb
    begin
        state_next.normal     = {(error_next != '0), (external_next != '0), normal_next};
        state_next.external   = external_next;
        state_next.error      = error_next;
        state_next.level_mask = level_mask_next;
        state_next.trig_mask  = trig_mask_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg     <= '0;
            external_reg   <= '0;
            error_reg      <= '0;
            level_mask_reg <= '0;
            trig_mask_reg  <= '0;
        end
        else if (advance)
        begin
            normal_reg     <= normal_next;
            external_reg   <= external_next;
            error_reg      <= error_next;
            level_mask_reg <= level_mask_next;
            trig_mask_reg  <= trig_mask_next;
        end
    end

endmodule

### src/pic_prio.sv
// ============================================================================
// pic_prio
// Masked level priority and DMA trigger matching on the updated state.
// ============================================================================
module pic_prio (
    input  pic_pkg::pic_state_t st,
    input  logic                wave_armed,
    input  logic                pvr_armed,
    output logic [2:0]          irq_level,
    output logic [3:0]          irl_code,
    output logic                wave_dma_trigger,
    output logic                pvr_dma_trigger
);
    import pic_pkg::*;

    logic hit2, hit4, hit6;

    assign hit2 = ((st.normal   & st.level_mask[LVL2_BASE])     |
                   (st.external & st.level_mask[LVL2_BASE + 1]) |
                   (st.error    & st.level_mask[LVL2_BASE + 2])) != '0;
    assign hit4 = ((st.normal   & st.level_mask[LVL4_BASE])     |
                   (st.external & st.level_mask[LVL4_BASE + 1]) |
                   (st.error    & st.level_mask[LVL4_BASE + 2])) != '0;
    assign hit6 = ((st.normal   & st.level_mask[LVL6_BASE])     |
                   (st.external & st.level_mask[LVL6_BASE + 1]) |
                   (st.error    & st.level_mask[LVL6_BASE + 2])) != '0;

    always_comb
    begin
        if (hit6)
            irq_level = LEVEL_6;
        else if (hit4)
            irq_level = LEVEL_4;
        else if (hit2)
            irq_level = LEVEL_2;
        else
            irq_level = LEVEL_NONE;
    end

    assign irl_code = IRL_TOP - {1'b0, irq_level};

    assign pvr_dma_trigger  = pvr_armed &&
        (((st.trig_mask[TRIG_PVR_NORMAL] & st.normal) |
          (st.trig_mask[TRIG_PVR_EXT]    & st.external)) != '0);
    assign wave_dma_trigger = wave_armed &&
        (((st.trig_mask[TRIG_G2_NORMAL] & st.normal) |
          (st.trig_mask[TRIG_G2_EXT]    & st.external)) != '0);

endmodule

### src/priority_interrupt_controller_top.sv
// ============================================================================
// priority_interrupt_controller_top
// Register-mapped interrupt controller with three priority levels.
// ============================================================================
// One transfer is accepted every clock cycle while the result side does not
// stall: the item is captured in an input register, the register file is
// updated and the level and trigger logic is evaluated in the same cycle,
// and the result is held in an output register until it is taken.
// Throughput is one item per cycle when not stalled, set by the register
// file update; back-pressure on the result side stalls both stages.
module priority_interrupt_controller_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // write_data[31:0], wave_armed[32], pvr_armed[33], zero[39:34]
    input  logic [pic_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // command[2:0], reg_index[6:3]
    input  logic [pic_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // read_data[31:0], irq_level[34:32], irl_code[38:35],
    // wave_dma_trigger[39], pvr_dma_trigger[40], zero[47:41]
    output logic [pic_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import pic_pkg::*;

    logic       in_valid_reg;
    item_t      item_reg;
    logic       out_valid_reg;
    result_t    result_reg;
    result_t    result_next;
    logic       advance;
    pic_state_t state_next;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg.command    <= cmd_t'(s_axis_tuser[2:0]);
            item_reg.reg_index  <= s_axis_tuser[6:3];
            item_reg.write_data <= s_axis_tdata[WORD_W-1:0];
            item_reg.wave_armed <= s_axis_tdata[WORD_W];
            item_reg.pvr_armed  <= s_axis_tdata[WORD_W+1];
        end
        if (advance)
            result_reg <= result_next;
    end

    pic_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item       (item_reg),
        .read_data  (result_next.read_data),
        .state_next (state_next)
    );

    pic_prio u_prio (
        .st               (state_next),
        .wave_armed       (item_reg.wave_armed),
        .pvr_armed        (item_reg.pvr_armed),
        .irq_level        (result_next.irq_level),
        .irl_code         (result_next.irl_code),
        .wave_dma_trigger (result_next.wave_dma_trigger),
        .pvr_dma_trigger  (result_next.pvr_dma_trigger)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, result_reg.pvr_dma_trigger, result_reg.wave_dma_trigger,
                            result_reg.irl_code, result_reg.irq_level, result_reg.read_data};

endmodule

### src/pic_checker.sv
// ============================================================================
// pic_checker
// Port-level checks on the interrupt controller's result stream and input ready.
// ============================================================================
module pic_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [pic_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import pic_pkg::*;

    a_irl_matches_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[38:35] == IRL_TOP - {1'b0, m_axis_tdata[34:32]}))
        else $error("Interrupt line code does not match the level.");

    a_level_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[34:32] == LEVEL_NONE || m_axis_tdata[34:32] == LEVEL_2 ||
                           m_axis_tdata[34:32] == LEVEL_4 || m_axis_tdata[34:32] == LEVEL_6))
        else $error("Interrupt level is not one of the defined levels.");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:41] == '0))
        else $error("Padding bits of the result transfer are not zero.");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("Stalled result transfer changed or was dropped.");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("Input is not ready although no result is waiting.");

endmodule

bind priority_interrupt_controller_top pic_checker u_pic_checker (.*);

### tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the priority interrupt controller. Register
// accesses and event transfers are driven with random gaps and back-pressure.
// A scoreboard holds its own copy of the status words and masks and checks
// every result field against the value it predicts.
// ============================================================================
module testbench;

    import pic_pkg::*;

    localparam logic [31:0] MIRROR_BITS   = 32'hC000_0000;
    localparam logic [31:0] ERR_MIRROR    = 32'h8000_0000;
    localparam logic [31:0] EXT_MIRROR    = 32'h4000_0000;
    localparam logic [2:0]  CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0]  CMD_UNUSED_HI = 3'd7;
    localparam logic [3:0]  REG_LVL2_NORMAL = 4'd3;
    localparam logic [3:0]  REG_LVL4_EXT    = 4'd7;
    localparam logic [3:0]  REG_LVL6_NORMAL = 4'd9;
    localparam logic [3:0]  REG_LVL6_ERROR  = 4'd11;
    localparam logic [3:0]  REG_PVR_NORMAL  = 4'd12;
    localparam logic [3:0]  REG_PVR_EXT     = 4'd13;
    localparam logic [3:0]  REG_G2_NORMAL   = 4'd14;
    localparam logic [3:0]  REG_G2_EXT      = 4'd15;
    localparam int          HOLD_CYCLES     = 200;
    localparam int          MAX_REPORTS     = 10;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [3:0]        reg_index;
        logic [WORD_W-1:0] data;
        logic              wave_armed;
        logic              pvr_armed;
    } bus_op_t;

    class irq_scoreboard;
        logic [WORD_W-1:0] normal_word;
        logic [WORD_W-1:0] external_word;
        logic [WORD_W-1:0] error_word;
        logic [WORD_W-1:0] level_mask [LEVEL_MASKS];
        logic [WORD_W-1:0] trig_mask [TRIG_MASKS];
        result_t           expected_q [$];
        int                mismatches;
        int                checked;
        int                reads;
        int                writes;
        int                events;
        int                unknown_ops;
        int                level_count [4];
        int                wave_fired;
        int                pvr_fired;

        function new();
            normal_word   = '0;
            external_word = '0;
            error_word    = '0;
            foreach (level_mask[i]) level_mask[i] = '0;
            foreach (trig_mask[i]) trig_mask[i] = '0;
            mismatches = 0;
            checked = 0;
            reads = 0;
            writes = 0;
            events = 0;
            unknown_ops = 0;
            foreach (level_count[i]) level_count[i] = 0;
            wave_fired = 0;
            pvr_fired = 0;
        endfunction

        function logic [WORD_W-1:0] reg_value(logic [3:0] idx);
            if (idx == REG_NORMAL) return normal_word;
            if (idx == REG_EXTERNAL) return external_word;
            if (idx == REG_ERROR) return error_word;
            if (idx <= REG_MASK_LAST) return level_mask[idx - REG_MASK_FIRST];
            return trig_mask[idx - REG_TRIG_FIRST];
        endfunction

        function bit level_hit(int base);
            return |((normal_word & level_mask[base]) |
                     (external_word & level_mask[base + 1]) |
                     (error_word & level_mask[base + 2]));
        endfunction

        function void note_item(bus_op_t op);
            result_t want;
            bit      wave_hit;
            bit      pvr_hit;
            want = '0;
            if (op.opcode == CMD_READ) begin
                reads++;
            end else if (op.opcode == CMD_WRITE) begin
                writes++;
                if (op.reg_index == REG_NORMAL)
                    normal_word &= ~(op.data | MIRROR_BITS);
                else if (op.reg_index == REG_ERROR)
                    error_word &= ~op.data;
                else if (op.reg_index >= REG_MASK_FIRST && op.reg_index <= REG_MASK_LAST)
                    level_mask[op.reg_index - REG_MASK_FIRST] = op.data;
                else if (op.reg_index >= REG_TRIG_FIRST)
                    trig_mask[op.reg_index - REG_TRIG_FIRST] = op.data;
            end else if (op.opcode == CMD_RAISE_NORMAL) begin
                events++;
                normal_word |= op.data;
            end else if (op.opcode == CMD_SET_EXTERNAL) begin
                events++;
                external_word = op.data;
            end else if (op.opcode == CMD_RAISE_ERROR) begin
                events++;
                error_word |= op.data;
            end else begin
                unknown_ops++;
            end

            normal_word = (normal_word & ~MIRROR_BITS)
                        | ((error_word != '0) ? ERR_MIRROR : '0)
                        | ((external_word != '0) ? EXT_MIRROR : '0);

            if (op.opcode == CMD_READ)
                want.read_data = reg_value(op.reg_index);

            if (level_hit(LVL6_BASE))
                want.irq_level = LEVEL_6;
            else if (level_hit(LVL4_BASE))
                want.irq_level = LEVEL_4;
            else if (level_hit(LVL2_BASE))
                want.irq_level = LEVEL_2;
            else
                want.irq_level = LEVEL_NONE;
            want.irl_code = IRL_TOP - {1'b0, want.irq_level};

            pvr_hit  = |((trig_mask[TRIG_PVR_NORMAL] & normal_word) |
                         (trig_mask[TRIG_PVR_EXT] & external_word));
            wave_hit = |((trig_mask[TRIG_G2_NORMAL] & normal_word) |
                         (trig_mask[TRIG_G2_EXT] & external_word));
            want.wave_dma_trigger = op.wave_armed & wave_hit;
            want.pvr_dma_trigger  = op.pvr_armed & pvr_hit;

            level_count[want.irq_level >> 1]++;
            if (want.wave_dma_trigger) wave_fired++;
            if (want.pvr_dma_trigger) pvr_fired++;
            expected_q.push_back(want);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: result transfer with nothing expected: %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.read_data !== want.read_data || got.irq_level !== want.irq_level ||
                got.irl_code !== want.irl_code ||
                got.wave_dma_trigger !== want.wave_dma_trigger ||
                got.pvr_dma_trigger !== want.pvr_dma_trigger) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("%0t: mismatch on result %0d", $time, checked);
                    $display("    read_data exp %h got %h, irq_level exp %0d got %0d",
                             want.read_data, got.read_data, want.irq_level, got.irq_level);
                    $display("    irl_code exp %0d got %0d, wave exp %b got %b, pvr exp %b got %b",
                             want.irl_code, got.irl_code, want.wave_dma_trigger,
                             got.wave_dma_trigger, want.pvr_dma_trigger, got.pvr_dma_trigger);
                end
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    irq_scoreboard sb;
    bit            quiet_phase;
    bit            hold_request;

    priority_interrupt_controller_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("** priority_interrupt_controller_top: FAILED **");
        $finish;
    end

    always @(posedge clk)
    begin
        result_t got;
        bus_op_t seen;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.read_data        = m_axis_tdata[31:0];
                got.irq_level        = m_axis_tdata[34:32];
                got.irl_code         = m_axis_tdata[38:35];
                got.wave_dma_trigger = m_axis_tdata[39];
                got.pvr_dma_trigger  = m_axis_tdata[40];
                sb.check_result(got);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                seen.opcode     = s_axis_tuser[2:0];
                seen.reg_index  = s_axis_tuser[6:3];
                seen.data       = s_axis_tdata[31:0];
                seen.wave_armed = s_axis_tdata[32];
                seen.pvr_armed  = s_axis_tdata[33];
                sb.note_item(seen);
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
            if (!quiet_phase && !hold_request && $urandom_range(0, 1) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    function automatic logic [WORD_W-1:0] sparse_word();
        case ($urandom_range(0, 3))
            0:       return 32'h1 << $urandom_range(0, 31);
            1:       return $urandom & $urandom & $urandom;
            2:       return '0;
            default: return $urandom & $urandom & $urandom & $urandom;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return '1;
            2:       return '0;
            default: return sparse_word();
        endcase
    endfunction

    function automatic bus_op_t random_op();
        bus_op_t op;
        int      pick;
        pick = $urandom_range(0, 99);
        op.reg_index  = 4'($urandom_range(0, 15));
        op.wave_armed = 1'($urandom_range(0, 1));
        op.pvr_armed  = 1'($urandom_range(0, 1));
        if (pick < 25)
            op.opcode = CMD_READ;
        else if (pick < 55)
            op.opcode = CMD_WRITE;
        else if (pick < 70)
            op.opcode = CMD_RAISE_NORMAL;
        else if (pick < 80)
            op.opcode = CMD_SET_EXTERNAL;
        else if (pick < 92)
            op.opcode = CMD_RAISE_ERROR;
        else
            op.opcode = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        if (op.opcode == CMD_WRITE && $urandom_range(0, 2) == 0)
            op.reg_index = 4'($urandom_range(REG_NORMAL, REG_ERROR));
        if (op.opcode == CMD_WRITE || op.opcode == CMD_READ)
            op.data = random_word();
        else
            op.data = sparse_word();
        return op;
    endfunction

    task automatic offer_op(input bus_op_t op);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, op.pvr_armed, op.wave_armed, op.data};
        s_axis_tuser  <= {op.reg_index, op.opcode};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic sender_gap();
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic issue(input logic [2:0] opcode, input logic [3:0] idx,
                         input logic [WORD_W-1:0] data, input logic wave, input logic pvr);
        bus_op_t op;
        op.opcode     = opcode;
        op.reg_index  = idx;
        op.data       = data;
        op.wave_armed = wave;
        op.pvr_armed  = pvr;
        sender_gap();
        offer_op(op);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            sender_gap();
            offer_op(random_op());
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
        @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        quiet_phase  = 1'b0;
        hold_request = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(CMD_READ,         REG_NORMAL,      32'h0000_0000, 1'b1, 1'b1);
        issue(CMD_WRITE,        REG_LVL2_NORMAL, 32'h0000_0001, 1'b0, 1'b0);
        issue(CMD_WRITE,        REG_LVL4_EXT,    32'h8000_0000, 1'b0, 1'b0);
        issue(CMD_WRITE,        REG_LVL6_ERROR,  32'h0000_0001, 1'b0, 1'b0);
        issue(CMD_WRITE,        REG_PVR_NORMAL,  EXT_MIRROR,    1'b0, 1'b0);
        issue(CMD_WRITE,        REG_G2_EXT,      32'hFFFF_FFFF, 1'b0, 1'b0);
        issue(CMD_RAISE_NORMAL, REG_ERROR,       32'hFFFF_FFFF, 1'b1, 1'b1);
        issue(CMD_READ,         REG_NORMAL,      32'hFFFF_FFFF, 1'b1, 1'b1);
        issue(CMD_SET_EXTERNAL, REG_NORMAL,      32'h8000_0000, 1'b1, 1'b1);
        issue(CMD_RAISE_ERROR,  REG_EXTERNAL,    32'h0000_0001, 1'b1, 1'b0);
        issue(CMD_WRITE,        REG_NORMAL,      32'hFFFF_FFFF, 1'b0, 1'b1);
        issue(CMD_WRITE,        REG_EXTERNAL,    32'hFFFF_FFFF, 1'b1, 1'b1);
        issue(CMD_READ,         REG_EXTERNAL,    32'h0000_0000, 1'b1, 1'b1);
        issue(CMD_WRITE,        REG_ERROR,       32'h0000_0001, 1'b1, 1'b1);
        issue(CMD_SET_EXTERNAL, REG_G2_EXT,      32'h0000_0000, 1'b1, 1'b1);
        issue(CMD_UNUSED_LO,    REG_NORMAL,      32'hFFFF_FFFF, 1'b1, 1'b1);
        issue(CMD_UNUSED_HI,    REG_ERROR,       32'hFFFF_FFFF, 1'b0, 1'b0);
        issue(CMD_READ,         REG_ERROR,       32'h0000_0000, 1'b0, 1'b0);
        issue(CMD_READ,         REG_LVL6_ERROR,  32'h0000_0000, 1'b0, 1'b0);
        issue(CMD_WRITE,        REG_PVR_EXT,     32'h0000_0000, 1'b0, 1'b0);
        issue(CMD_WRITE,        REG_G2_NORMAL,   32'hFFFF_FFFF, 1'b0, 1'b0);
        issue(CMD_WRITE,        REG_LVL6_NORMAL, 32'hFFFF_FFFF, 1'b0, 1'b0);
        issue(CMD_RAISE_NORMAL, REG_NORMAL,      32'h0000_0000, 1'b1, 1'b1);
        issue(CMD_READ,         REG_PVR_EXT,     32'h0000_0000, 1'b1, 1'b0);
        issue(CMD_READ,         REG_G2_NORMAL,   32'h0000_0000, 1'b0, 1'b1);

        run_random(250);
        drain_results();

        hold_request = 1'b1;
        for (int i = 0; i < 40; i++) offer_op(random_op());

        run_random(350);
        drain_results();

        quiet_phase = 1'b1;
        run_random(110);

        drain_results();
        repeat (10) @(posedge clk);

        $display("Checked %0d results: %0d reads, %0d writes, %0d events, %0d unknown commands.",
                 sb.checked, sb.reads, sb.writes, sb.events, sb.unknown_ops);
        $display("Levels 0/2/4/6 seen %0d/%0d/%0d/%0d times; wave DMA %0d, PVR DMA %0d triggers.",
                 sb.level_count[0], sb.level_count[1], sb.level_count[2], sb.level_count[3],
                 sb.wave_fired, sb.pvr_fired);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("** priority_interrupt_controller_top: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.pending());
            $display("** priority_interrupt_controller_top: FAILED **");
        end
        $finish;
    end

endmodule
